### rtl/date_time_string_parse_validate_macros.svh
// Assertion macros for the date stamp parser.
// Each assertion samples on the rising edge of clock and is disabled in reset.
`ifndef DATE_TIME_STRING_PARSE_VALIDATE_MACROS_SVH
`define DATE_TIME_STRING_PARSE_VALIDATE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define DTSP_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication.
`define DTSP_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define DTSP_ASSERT_IMP(label, ante, cons)
`define DTSP_ASSERT_NXT(label, ante, cons)

`endif

`endif

### rtl/dtsp_pkg.sv
`timescale 1ns / 1ps

package dtsp_pkg;

   localparam int StampLen   = 16;
   localparam int CharWidth  = 8;
   localparam int DigitWidth = 4;

   // Character positions of the separators in "YYYY-MM-DD/HH:MM".
   localparam int PosDashYear  = 4;
   localparam int PosDashMonth = 7;
   localparam int PosSlash     = 10;
   localparam int PosColon     = 13;

   localparam logic [CharWidth-1:0] CharZero  = 8'h30;
   localparam logic [CharWidth-1:0] CharNine  = 8'h39;
   localparam logic [CharWidth-1:0] CharDash  = 8'h2D;
   localparam logic [CharWidth-1:0] CharSlash = 8'h2F;
   localparam logic [CharWidth-1:0] CharColon = 8'h3A;

   // What one cell reports about the character it holds.
   typedef struct packed {
      logic                  filled;
      logic                  is_digit;
      logic [DigitWidth-1:0] digit;
      logic                  is_dash;
      logic                  is_slash;
      logic                  is_colon;
   } cell_stat_type;

   typedef struct packed {
      logic        date_valid;
      logic [13:0] year_value;
      logic [3:0]  month_value;
      logic [4:0]  day_value;
      logic [4:0]  hour_value;
      logic [5:0]  minute_value;
   } rsp_data_type;

   // Value of two decimal digits, 0 to 99.
   function automatic logic [6:0] two_digit_f(input logic [DigitWidth-1:0] tens,
                                               input logic [DigitWidth-1:0] ones);
      return 7'(tens) * 7'd10 + 7'(ones);
   endfunction

   // A two-digit decimal number 10a+b is divisible by 4 exactly when 2a+b is.
   function automatic logic div4_f(input logic [DigitWidth-1:0] tens,
                                   input logic [DigitWidth-1:0] ones);
      logic [1:0] low;
      low = {tens[0], 1'b0} + ones[1:0];
      return low == 2'd0;
   endfunction

   // Gregorian leap rule from the four year digits: a century year is leap
   // when its century is divisible by 4, any other year when its last two
   // digits are.
   function automatic logic leap_f(input logic [DigitWidth-1:0] d0,
                                   input logic [DigitWidth-1:0] d1,
                                   input logic [DigitWidth-1:0] d2,
                                   input logic [DigitWidth-1:0] d3);
      logic century;
      century = (d2 == '0) && (d3 == '0);
      return century ? div4_f(d0, d1) : div4_f(d2, d3);
   endfunction

   function automatic logic [4:0] month_days_f(input logic [6:0] month, input logic leap);
      logic [4:0] days;
      case (month) inside
         7'd4, 7'd6, 7'd9, 7'd11: days = 5'd30;
         7'd2:                    days = leap ? 5'd29 : 5'd28;
         default:                 days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

### rtl/dtsp_req_if.sv
`timescale 1ns / 1ps

interface dtsp_req_if import dtsp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] char_code;
   logic                 last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

### rtl/dtsp_rsp_if.sv
`timescale 1ns / 1ps

interface dtsp_rsp_if;
   logic        valid;
   logic        ready;
   logic        date_valid;
   logic [13:0] year_value;
   logic [3:0]  month_value;
   logic [4:0]  day_value;
   logic [4:0]  hour_value;
   logic [5:0]  minute_value;

   modport source (output valid, output date_valid, output year_value, output month_value,
                   output day_value, output hour_value, output minute_value, input ready);
   modport sink   (input valid, input date_valid, input year_value, input month_value,
                   input day_value, input hour_value, input minute_value, output ready);
endinterface

### rtl/dtsp_cell.sv
`timescale 1ns / 1ps

module dtsp_cell
   import dtsp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  logic                 flush,
   input  logic [CharWidth-1:0] char_in,
   input  logic                 filled_in,
   output logic [CharWidth-1:0] char_out,
   output cell_stat_type        status
);

   logic [CharWidth-1:0] char_ff;
   logic                 filled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= 1'b0;
      end else if (shift_en) begin
         filled_ff <= filled_in;
      end else if (flush) begin
         filled_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         char_ff <= char_in;
      end
   end

   // Digits '0' to '9' carry their value in the low nibble.
   always_comb begin
      status.filled   = filled_ff;
      status.is_digit = (char_ff >= CharZero) && (char_ff <= CharNine);
      status.digit    = char_ff[DigitWidth-1:0];
      status.is_dash  = char_ff == CharDash;
      status.is_slash = char_ff == CharSlash;
      status.is_colon = char_ff == CharColon;
   end

   assign char_out = char_ff;

endmodule

### rtl/date_time_string_parse_validate.sv
`timescale 1ns / 1ps

// Date stamp parser and validator. Characters of a "YYYY-MM-DD/HH:MM" stamp
// arrive one per beat on req_ch, with last_char set on the final one, and
// each stamp yields exactly one beat on rsp_ch. The characters enter a row of
// sixteen cells that shifts by one on every accepted beat and stops once it
// holds sixteen characters, so any later characters are dropped. Once the
// last character is in, the stamp is marked pending; as soon as the output
// register is free, the row is checked as a whole (separators, digits, year
// 1000 to 9999, month 1 to 12, day against the month length with the
// Gregorian leap rule, hour to 23, minute to 59), the verdict is loaded into
// the output register and the row is emptied. A failed check or a stamp
// shorter than sixteen characters gives a beat with every field zero. The
// block takes one character per cycle without gaps, also across stamp
// boundaries, except for the stall below. The output register presents the
// result beat on rsp_ch. The only stall comes from the output register:
// while it holds an untaken result and a second finished stamp waits for
// it, req_ch.ready is low.
module date_time_string_parse_validate
   import dtsp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   dtsp_req_if.sink   req_ch,
   dtsp_rsp_if.source rsp_ch
);

   `include "date_time_string_parse_validate_macros.svh"

   // Cell k holds the character that arrived k beats before the newest one,
   // so once the row is full, stamp position p sits in cell StampLen-1-p.
   logic [CharWidth-1:0] cell_char [StampLen];
   cell_stat_type        cell_stat [StampLen];
   logic [StampLen-1:0]  filled_vec;

   logic         req_fire;
   logic         row_full;
   logic         shift_en;
   logic         flush;
   logic         out_free;
   logic         eval_pending_ff;
   logic         eval_pending_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_data_type rsp_data_ff;
   rsp_data_type rsp_data_in;

   // Handshake and row control.
   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = !eval_pending_ff || out_free;
   assign req_fire      = req_ch.valid && req_ch.ready;
   assign flush         = eval_pending_ff && out_free;
   assign row_full      = cell_stat[StampLen-1].filled;
   // Past the sixteenth character the row freezes; a flush reopens it so the
   // first character of the next stamp can enter in the same cycle.
   assign shift_en      = req_fire && (!row_full || flush);

   assign eval_pending_in = (req_fire && req_ch.last_char) || (eval_pending_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_pending_ff <= 1'b0;
      end else begin
         eval_pending_ff <= eval_pending_in;
      end
   end

   // The row of cells. A flush empties every cell; the first takes the
   // incoming character when there is one.
   genvar gi;
   generate
      for (gi = 0; gi < StampLen; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            dtsp_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .shift_en  (shift_en),
               .flush     (flush),
               .char_in   (req_ch.char_code),
               .filled_in (1'b1),
               .char_out  (cell_char[gi]),
               .status    (cell_stat[gi])
            );
         end else begin : g_body
            dtsp_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .shift_en  (shift_en),
               .flush     (flush),
               .char_in   (cell_char[gi-1]),
               .filled_in (cell_stat[gi-1].filled && !flush),
               .char_out  (cell_char[gi]),
               .status    (cell_stat[gi])
            );
         end
         assign filled_vec[gi] = cell_stat[gi].filled;
      end
   endgenerate

   // Checks over the whole row. The position of each character is fixed by
   // its cell, so the format test is a set of independent per-cell checks.
   logic                  format_ok;
   logic [DigitWidth-1:0] dg [StampLen];
   logic [6:0]            cent_val;
   logic [6:0]            yy_val;
   logic [6:0]            month_val;
   logic [6:0]            day_val;
   logic [6:0]            hour_val;
   logic [6:0]            minute_val;
   logic [13:0]           year_val;
   logic                  leap;
   logic [4:0]            days_in_month;
   logic                  range_ok;

   always_comb begin
      format_ok = row_full;
      for (int p = 0; p < StampLen; p++) begin
         dg[p] = cell_stat[StampLen-1-p].digit;
         case (p) inside
            PosDashYear, PosDashMonth: format_ok &= cell_stat[StampLen-1-p].is_dash;
            PosSlash:                  format_ok &= cell_stat[StampLen-1-p].is_slash;
            PosColon:                  format_ok &= cell_stat[StampLen-1-p].is_colon;
            default:                   format_ok &= cell_stat[StampLen-1-p].is_digit;
         endcase
      end

      cent_val      = two_digit_f(dg[0], dg[1]);
      yy_val        = two_digit_f(dg[2], dg[3]);
      month_val     = two_digit_f(dg[5], dg[6]);
      day_val       = two_digit_f(dg[8], dg[9]);
      hour_val      = two_digit_f(dg[11], dg[12]);
      minute_val    = two_digit_f(dg[14], dg[15]);
      year_val      = 14'(cent_val) * 14'd100 + 14'(yy_val);
      leap          = leap_f(dg[0], dg[1], dg[2], dg[3]);
      days_in_month = month_days_f(month_val, leap);

      // With four digits the year is never above 9999, and it reaches 1000
      // exactly when the leading digit is not zero.
      range_ok = (dg[0] != '0)
              && (month_val >= 7'd1) && (month_val <= 7'd12)
              && (day_val >= 7'd1) && (day_val <= 7'(days_in_month))
              && (hour_val <= 7'd23) && (minute_val <= 7'd59);

      rsp_data_in = '0;
      if (format_ok && range_ok) begin
         rsp_data_in.date_valid   = 1'b1;
         rsp_data_in.year_value   = year_val;
         rsp_data_in.month_value  = month_val[3:0];
         rsp_data_in.day_value    = day_val[4:0];
         rsp_data_in.hour_value   = hour_val[4:0];
         rsp_data_in.minute_value = minute_val[5:0];
      end
   end

   // Output register: loaded on a flush, held while the sink stalls.
   assign rsp_valid_in = flush || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (flush) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.date_valid   = rsp_data_ff.date_valid;
   assign rsp_ch.year_value   = rsp_data_ff.year_value;
   assign rsp_ch.month_value  = rsp_data_ff.month_value;
   assign rsp_ch.day_value    = rsp_data_ff.day_value;
   assign rsp_ch.hour_value   = rsp_data_ff.hour_value;
   assign rsp_ch.minute_value = rsp_data_ff.minute_value;

   // A flushed stamp always reaches the output register in the next cycle.
   `DTSP_ASSERT_NXT(a_flush_loads_output, flush, rsp_valid_ff)
   // The input side only stalls behind a finished stamp.
   `DTSP_ASSERT_IMP(a_stall_needs_pending, !req_ch.ready, eval_pending_ff && rsp_valid_ff)
   // After a flush at most the first cell holds a character.
   `DTSP_ASSERT_NXT(a_flush_empties_row, flush, $countones(filled_vec[StampLen-1:1]) == 0)
   // A rejected stamp carries all-zero fields.
   `DTSP_ASSERT_IMP(a_invalid_is_zero, rsp_valid_ff && !rsp_data_ff.date_valid,
                    rsp_data_ff == '0)
   // An accepted stamp has a real month and a year of at least 1000.
   `DTSP_ASSERT_IMP(a_valid_ranges, rsp_valid_ff && rsp_data_ff.date_valid,
                    rsp_data_ff.month_value >= 4'd1 && rsp_data_ff.month_value <= 4'd12
                    && rsp_data_ff.year_value >= 14'd1000)

endmodule

### tb/tb_date_time_string_parse_validate.sv
`timescale 1ns / 1ps

// Checks the stamp parser: drives "YYYY-MM-DD/HH:MM" text one character per
// beat and holds each result beat to a cycle-free predictor or typed verdict.
module tb_date_time_string_parse_validate;
   import dtsp_pkg::*;

   // The run is stopped with a failure if it goes on this long.
   localparam int CycleLimit = 200000;

   // Stimulus stops once about this many characters have been accepted.
   localparam int CharTarget = 1450;

   // The random part runs without any idling between these character counts.
   localparam int SteadyFrom  = 700;
   localparam int SteadyUntil = 1050;

   localparam int IdlePercent = 7;

   localparam rsp_data_type NoDate = '0;

   typedef logic [CharWidth-1:0] stamp_bytes_type[$];

   // One row of the directed table. Rows with has_verdict set carry the
   // result typed in by hand; the others are checked against the predictor.
   typedef struct {
      string        text;
      bit           has_verdict;
      rsp_data_type verdict;
   } stamp_row_type;

   localparam int NumRows = 25;

   stamp_row_type directed_rows[NumRows] = '{
      // Smallest and largest fields that still give a valid stamp.
      '{"1000-01-01/00:00", 1'b1, '{1'b1, 14'd1000, 4'd1, 5'd1, 5'd0, 6'd0}},
      '{"9999-12-31/23:59", 1'b1, '{1'b1, 14'd9999, 4'd12, 5'd31, 5'd23, 6'd59}},
      // Year one below the allowed range.
      '{"0999-12-31/23:59", 1'b1, NoDate},
      // Leap day in an ordinary leap year, a common year and century years.
      '{"2024-02-29/12:30", 1'b0, NoDate},
      '{"2023-02-29/12:30", 1'b1, NoDate},
      '{"1900-02-29/06:15", 1'b1, NoDate},
      '{"2000-02-29/06:15", 1'b0, NoDate},
      '{"1600-02-29/00:00", 1'b0, NoDate},
      // Day past the end of a thirty-day month.
      '{"2021-04-31/08:00", 1'b1, NoDate},
      // Month, day, hour and minute just outside their ranges.
      '{"2021-13-01/08:00", 1'b1, NoDate},
      '{"2021-00-10/08:00", 1'b1, NoDate},
      '{"2021-05-00/08:00", 1'b1, NoDate},
      '{"2021-05-10/24:00", 1'b1, NoDate},
      '{"2021-05-10/23:60", 1'b1, NoDate},
      // A wrong character at each of the four separator positions.
      '{"2021/05-10/23:59", 1'b1, NoDate},
      '{"2021-05/10/23:59", 1'b1, NoDate},
      '{"2021-05-10 23:59", 1'b1, NoDate},
      '{"2021-05-10/23-59", 1'b1, NoDate},
      // Non-digits at digit positions, including the codes right next to
      // the digit range.
      '{"20a1-05-10/23:59", 1'b1, NoDate},
      '{"2021-05-10/23:5:", 1'b1, NoDate},
      '{"/021-05-10/23:59", 1'b1, NoDate},
      // Stamps that end early.
      '{"2021-05-10", 1'b1, NoDate},
      '{"9", 1'b1, NoDate},
      // Characters past the sixteenth are dropped, so these stay valid.
      '{"2021-06-30/23:59:59", 1'b0, NoDate},
      '{"2021-11-30/00:01\377", 1'b0, NoDate}
   };

   logic clock = 1'b0;
   logic reset;

   dtsp_req_if req_ch ();
   dtsp_rsp_if rsp_ch ();

   date_time_string_parse_validate dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // Predictor state: position within the current stamp, the sticky format
   // error and the decimal values built up so far.
   logic [4:0]  stamp_pos  = '0;
   logic        stamp_bad  = 1'b0;
   logic [13:0] year_acc   = '0;
   logic [6:0]  month_acc  = '0;
   logic [6:0]  day_acc    = '0;
   logic [6:0]  hour_acc   = '0;
   logic [6:0]  minute_acc = '0;

   // Verdicts of finished stamps, oldest first, waiting for their beat.
   rsp_data_type expected_stamps[$];
   rsp_data_type oldest_stamp;

   bit idling_on = 1'b1;
   int cycle_count = 0;
   int mismatch_count = 0;
   int chars_sent = 0;
   int stamps_sent = 0;
   int valid_seen = 0;

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Takes one accepted character into the predictor. On the last character
   // of a stamp it hands back the verdict and clears the stamp state.
   task automatic parse_stamp_char(input logic [CharWidth-1:0] c, input logic last,
                                   output rsp_data_type verdict);
      logic is_digit;
      int   digit;
      bit   leap;
      int   month_len;
      bit   ok;
      is_digit = (c >= CharZero) && (c <= CharNine);
      digit = is_digit ? int'(c - CharZero) : 0;
      verdict = NoDate;
      if (stamp_pos < StampLen) begin
         case (int'(stamp_pos))
            PosDashYear, PosDashMonth: begin
               if (c != CharDash) stamp_bad = 1'b1;
            end
            PosSlash: begin
               if (c != CharSlash) stamp_bad = 1'b1;
            end
            PosColon: begin
               if (c != CharColon) stamp_bad = 1'b1;
            end
            default: begin
               // A bad digit only marks the stamp; the value is left as it was.
               if (!is_digit)
                  stamp_bad = 1'b1;
               else if (stamp_pos <= 3)
                  year_acc = 14'((year_acc % 1000) * 10 + digit);
               else if (stamp_pos <= 6)
                  month_acc = 7'((month_acc % 10) * 10 + digit);
               else if (stamp_pos <= 9)
                  day_acc = 7'((day_acc % 10) * 10 + digit);
               else if (stamp_pos <= 12)
                  hour_acc = 7'((hour_acc % 10) * 10 + digit);
               else
                  minute_acc = 7'((minute_acc % 10) * 10 + digit);
            end
         endcase
         stamp_pos++;
      end
      if (last) begin
         leap = (year_acc % 400 == 0) || ((year_acc % 4 == 0) && (year_acc % 100 != 0));
         case (int'(month_acc))
            4, 6, 9, 11: month_len = 30;
            2:           month_len = leap ? 29 : 28;
            default:     month_len = 31;
         endcase
         ok = (stamp_pos >= StampLen) && !stamp_bad
            && (year_acc >= 1000) && (year_acc <= 9999)
            && (month_acc >= 1) && (month_acc <= 12)
            && (day_acc >= 1) && (day_acc <= month_len)
            && (hour_acc <= 23) && (minute_acc <= 59);
         if (ok)
            verdict = '{1'b1, year_acc, 4'(month_acc), 5'(day_acc), 5'(hour_acc),
                        6'(minute_acc)};
         stamp_pos = '0;
         stamp_bad = 1'b0;
         year_acc = '0;
         month_acc = '0;
         day_acc = '0;
         hour_acc = '0;
         minute_acc = '0;
      end
   endtask

   // Sends one stamp, a beat per character with last_char on the final one.
   // Valid stays high from one character to the next unless an idle cycle is
   // rolled, so back-to-back beats also span stamp boundaries. Once the last
   // beat is accepted, the verdict is queued: the typed one if given, else
   // the predicted one.
   task automatic send_stamp(input stamp_bytes_type stamp, input bit has_verdict,
                             input rsp_data_type typed_verdict);
      rsp_data_type verdict;
      for (int i = 0; i < stamp.size(); i++) begin
         while (idling_on && ($urandom_range(0, 99) < IdlePercent)) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
         req_ch.valid     <= 1'b1;
         req_ch.char_code <= stamp[i];
         req_ch.last_char <= (i == stamp.size() - 1);
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         chars_sent++;
         parse_stamp_char(stamp[i], i == stamp.size() - 1, verdict);
      end
      expected_stamps.push_back(has_verdict ? typed_verdict : verdict);
      stamps_sent++;
   endtask

   // The result side stalls at random while idling is on, and takes every
   // beat during the steady stretch.
   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= !(idling_on && ($urandom_range(0, 99) < IdlePercent));
   end

   // Every accepted result beat is matched against the oldest pending stamp,
   // field by field.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_stamps.size() == 0) begin
            report_mismatch("result beat with no stamp pending");
         end else begin
            oldest_stamp = expected_stamps.pop_front();
            if (rsp_ch.date_valid) valid_seen++;
            if (rsp_ch.date_valid !== oldest_stamp.date_valid)
               report_mismatch($sformatf("date_valid got %0b, expected %0b",
                                         rsp_ch.date_valid, oldest_stamp.date_valid));
            if (rsp_ch.year_value !== oldest_stamp.year_value)
               report_mismatch($sformatf("year_value got %0d, expected %0d",
                                         rsp_ch.year_value, oldest_stamp.year_value));
            if (rsp_ch.month_value !== oldest_stamp.month_value)
               report_mismatch($sformatf("month_value got %0d, expected %0d",
                                         rsp_ch.month_value, oldest_stamp.month_value));
            if (rsp_ch.day_value !== oldest_stamp.day_value)
               report_mismatch($sformatf("day_value got %0d, expected %0d",
                                         rsp_ch.day_value, oldest_stamp.day_value));
            if (rsp_ch.hour_value !== oldest_stamp.hour_value)
               report_mismatch($sformatf("hour_value got %0d, expected %0d",
                                         rsp_ch.hour_value, oldest_stamp.hour_value));
            if (rsp_ch.minute_value !== oldest_stamp.minute_value)
               report_mismatch($sformatf("minute_value got %0d, expected %0d",
                                         rsp_ch.minute_value, oldest_stamp.minute_value));
         end
      end
   end

   // A hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles with %0d stamps pending", cycle_count,
                  expected_stamps.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      stamp_bytes_type stamp;
      string           text;
      int year, month, day, hour, minute;
      int pick;
      int stamp_len;

      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.char_code <= '0;
      req_ch.last_char <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table first.
      foreach (directed_rows[r]) begin
         stamp = {};
         for (int j = 0; j < directed_rows[r].text.len(); j++)
            stamp.push_back(directed_rows[r].text[j]);
         send_stamp(stamp, directed_rows[r].has_verdict, directed_rows[r].verdict);
      end
      // A lone zero byte as a whole stamp: too short, so all fields are zero.
      stamp = {};
      stamp.push_back('0);
      send_stamp(stamp, 1'b1, NoDate);

      // Random part. Most stamps are well formed with random field values
      // weighted toward the range edges, February and century years; some of
      // those get a character replaced, are cut short or run long. The rest
      // are runs of arbitrary bytes.
      while (chars_sent < CharTarget) begin
         idling_on = !((chars_sent >= SteadyFrom) && (chars_sent < SteadyUntil));
         stamp = {};
         if ($urandom_range(0, 99) < 80) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
               year = $urandom_range(0, 999);
            else if (pick < 25)
               year = $urandom_range(10, 99) * 100;
            else
               year = $urandom_range(1000, 9999);

            if ($urandom_range(0, 99) < 90)
               month = $urandom_range(1, 12);
            else
               month = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);

            pick = $urandom_range(0, 99);
            if (pick < 60)
               day = $urandom_range(1, 28);
            else if (pick < 90)
               day = $urandom_range(28, 31);
            else if (pick < 95)
               day = 0;
            else
               day = $urandom_range(32, 99);

            // Extra weight on the end of February.
            if ($urandom_range(0, 99) < 20) begin
               month = 2;
               day = $urandom_range(28, 30);
            end

            hour = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 23)
                                                 : $urandom_range(24, 99);
            minute = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 59)
                                                   : $urandom_range(60, 99);

            text = $sformatf("%04d-%02d-%02d/%02d:%02d", year, month, day, hour, minute);
            for (int j = 0; j < text.len(); j++)
               stamp.push_back(text[j]);

            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               stamp[$urandom_range(0, StampLen - 1)] = CharWidth'($urandom_range(0, 255));
            end else if (pick < 14) begin
               stamp_len = $urandom_range(1, StampLen - 1);
               while (stamp.size() > stamp_len) void'(stamp.pop_back());
            end else if (pick < 20) begin
               repeat ($urandom_range(1, 6))
                  stamp.push_back(CharWidth'($urandom_range(0, 255)));
            end
         end else begin
            repeat ($urandom_range(1, 20))
               stamp.push_back(CharWidth'($urandom_range(0, 255)));
         end
         send_stamp(stamp, 1'b0, NoDate);
      end
      req_ch.valid <= 1'b0;
      idling_on = 1'b1;

      // Drain, then keep watching the result side so that a stray extra beat
      // would still be seen.
      while (expected_stamps.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      $display("Sent %0d stamps in %0d characters; %0d valid dates came back.",
               stamps_sent, chars_sent, valid_seen);
      $display("Mismatches found: %0d.", mismatch_count);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### date_time_string_parse_validate.f
+incdir+rtl
rtl/dtsp_pkg.sv
rtl/dtsp_req_if.sv
rtl/dtsp_rsp_if.sv
rtl/dtsp_cell.sv
rtl/date_time_string_parse_validate.sv
tb/tb_date_time_string_parse_validate.sv
